>>> design/gtr_pkg.sv
// ----------------------------------------------------------------------------
// gtr_pkg
// Types, codes and the 5x8 column font shared by the text rasterizer.
// ----------------------------------------------------------------------------
package gtr_pkg;

  localparam int GLYPH_WIDTH  = 5;
  localparam int GLYPH_HEIGHT = 8;
  localparam int GLYPH_COUNT  = 91;
  localparam int ROW_BITS     = GLYPH_WIDTH * GLYPH_HEIGHT;

  localparam logic [7:0] FIRST_CODE   = 8'd32;
  localparam logic [7:0] LAST_CODE    = 8'd122;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] END_CODE     = 8'h00;
  localparam logic [6:0] COUNT_MAX    = 7'd127;

  localparam logic [2:0] LAST_ROW = 3'(GLYPH_HEIGHT - 1);
  localparam logic [2:0] LAST_COL = 3'(GLYPH_WIDTH - 1);

  // configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X      = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y      = 3'd1;
  localparam logic [2:0] REG_VERTICAL_MODE = 3'd2;
  localparam logic [2:0] REG_FG_COLOR      = 3'd3;
  localparam logic [2:0] REG_BG_COLOR      = 3'd4;

  localparam logic KIND_WINDOW = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  typedef struct packed {
    logic [7:0] char_code;
    logic       string_start;
  } char_word_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  win_x0;
    logic [7:0]  win_y0;
    logic [7:0]  win_x1;
    logic [7:0]  win_y1;
    logic [23:0] pixel_color;
    logic [6:0]  glyphs_drawn;
    logic        last;
  } result_word_t;

  typedef struct packed {
    logic [7:0]  origin_x;
    logic [7:0]  origin_y;
    logic        vertical_mode;
    logic [23:0] fg_color;
    logic [23:0] bg_color;
  } cfg_t;

  // what the cursor logic decides for the character on the input
  typedef struct packed {
    logic       draw;
    logic [7:0] x0;
    logic [7:0] y0;
    logic [6:0] glyphs;
  } draw_cmd_t;

  // one row per glyph, column bytes 0..4 from the most significant end
  localparam logic [ROW_BITS-1:0] FONT [GLYPH_COUNT] = '{
    40'h0000000000, 40'h00009E0000, 40'h000E000E00, 40'h28FE28FE28,
    40'h4854FE5424, 40'h462610C8C4, 40'h6C92AA4480, 40'h000A060000,
    40'h0038448200, 40'h0082443800, 40'h28107C1028, 40'h10107C1010,
    40'h00A0600000, 40'h1010101010, 40'h00C0C00000, 40'h4020100804,
    40'h7CA2928A7C, 40'h0084FE8000, 40'h84C2A2928C, 40'h42828A9662,
    40'h302824FE20, 40'h4E8A8A8A72, 40'h7894929260, 40'h02E2120A06,
    40'h6C9292926C, 40'h0C9292523C, 40'h006C6C0000, 40'h00AC6C0000,
    40'h1028448200, 40'h2828282828, 40'h8244281000, 40'h0402A2120C,
    40'h6492F2827C, 40'hFC222222FC, 40'hFE9292926C, 40'h7C82828244,
    40'hFE8282827C, 40'hFE92929282, 40'hFE12121202, 40'h7C829292F4,
    40'hFE101010FE, 40'h0082FE8200, 40'h4080827E02, 40'hFE10284482,
    40'hFE80808080, 40'hFE040804FE, 40'hFE081020FE, 40'h7C8282827C,
    40'hFE1212120C, 40'h7C82A242BC, 40'hFE1232528C, 40'h8C92929262,
    40'h0202FE0202, 40'h7E8080807E, 40'h3E4080403E, 40'h7E8070807E,
    40'hC6281028C6, 40'h0E10E0100E, 40'hC2A2928A86, 40'h00FE828200,
    40'h0408102040, 40'h008282FE00, 40'h0804020408, 40'h8080808080,
    40'h0002040800, 40'h40A8A8A8F0, 40'hFE90888870, 40'h7088888840,
    40'h70888890FE, 40'h70A8A8A830, 40'h10FC120204, 40'h0C9292927E,
    40'hFE100808F0, 40'h0088FA8000, 40'h4080887A00, 40'hFE20508800,
    40'h0082FE8000, 40'hF808F008F0, 40'hF8100808F0, 40'h7088888870,
    40'hF828282810, 40'h10282830F8, 40'hF810080810, 40'h90A8A8A848,
    40'h047E848040, 40'h78808040F8, 40'h3840804038, 40'h7880608078,
    40'h8850205088, 40'h18A0A0A078, 40'h88C8A89888
  };

  // out-of-range codes map to the blank glyph
  function automatic logic [6:0] glyph_index(input logic [7:0] code);
    logic [7:0] diff;
    diff = code - FIRST_CODE;
    if (code >= FIRST_CODE && code <= LAST_CODE) begin
      return diff[6:0];
    end
    return 7'd0;
  endfunction

endpackage

>>> design/gtr_chan_if.sv
// ----------------------------------------------------------------------------
// gtr_chan_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface gtr_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> design/gtr_font_rom.sv
// ----------------------------------------------------------------------------
// gtr_font_rom
// Synchronous font ROM with registered read, one glyph row of 40 bits per entry.
// ----------------------------------------------------------------------------
module gtr_font_rom
  import gtr_pkg::*;
(
  input  logic                clk,
  input  logic                rd_en,
  input  logic [6:0]          addr,
  output logic [ROW_BITS-1:0] data
);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (addr < 7'(GLYPH_COUNT)) begin
        data <= FONT[addr];
      end else begin
        data <= '0;
      end
    end
  end

endmodule

>>> design/gtr_cursor.sv
// ----------------------------------------------------------------------------
// gtr_cursor
// Cursor, string counters and end mark; decides what each character does.
// ----------------------------------------------------------------------------
module gtr_cursor
  import gtr_pkg::*;
#(
  parameter int MAX_STRING_CHARS = 64
)(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       accept,
  input  char_word_t word,
  output draw_cmd_t  cmd
);

  localparam logic [7:0] MAX_CHARS = 8'(MAX_STRING_CHARS);

  logic [7:0] cursor_col, cursor_row;
  logic [6:0] chars_seen, drawn_count;
  logic       string_ended;

  logic [7:0] col_eff, row_eff, cursor_col_next, cursor_row_next;
  logic [6:0] seen_eff, drawn_eff, chars_seen_next, drawn_count_next;
  logic       ended_eff, string_ended_next;

  always_comb begin
    col_eff   = word.string_start ? cfg.origin_x : cursor_col;
    row_eff   = word.string_start ? cfg.origin_y : cursor_row;
    seen_eff  = word.string_start ? 7'd0 : chars_seen;
    drawn_eff = word.string_start ? 7'd0 : drawn_count;
    ended_eff = word.string_start ? 1'b0 : string_ended;

    cursor_col_next   = col_eff;
    cursor_row_next   = row_eff;
    chars_seen_next   = seen_eff;
    drawn_count_next  = drawn_eff;
    string_ended_next = ended_eff;
    cmd.draw          = 1'b0;

    if (!ended_eff) begin
      if ({1'b0, seen_eff} >= MAX_CHARS || word.char_code == END_CODE) begin
        string_ended_next = 1'b1;
      end else begin
        if (seen_eff != COUNT_MAX) begin
          chars_seen_next = seen_eff + 7'd1;
        end
        if (word.char_code == NEWLINE_CODE) begin
          cursor_col_next = cfg.origin_x;
          cursor_row_next = row_eff + 8'(GLYPH_HEIGHT);
        end else begin
          cmd.draw = 1'b1;
          if (drawn_eff != COUNT_MAX) begin
            drawn_count_next = drawn_eff + 7'd1;
          end
          if (cfg.vertical_mode) begin
            cursor_row_next = row_eff + 8'(GLYPH_HEIGHT);
          end else begin
            cursor_col_next = col_eff + 8'(GLYPH_WIDTH);
          end
        end
      end
    end

    cmd.x0     = col_eff;
    cmd.y0     = row_eff;
    cmd.glyphs = drawn_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col   <= '0;
      cursor_row   <= '0;
      chars_seen   <= '0;
      drawn_count  <= '0;
      string_ended <= 1'b0;
    end else if (accept) begin
      cursor_col   <= cursor_col_next;
      cursor_row   <= cursor_row_next;
      chars_seen   <= chars_seen_next;
      drawn_count  <= drawn_count_next;
      string_ended <= string_ended_next;
    end
  end

endmodule

>>> design/gtr_pixel_seq.sv
// ----------------------------------------------------------------------------
// gtr_pixel_seq
// Output register and row/column sequencer: window word, then 40 pixels.
// ----------------------------------------------------------------------------
module gtr_pixel_seq
  import gtr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                start,
  input  draw_cmd_t           cmd,
  input  logic [ROW_BITS-1:0] glyph_row,
  output logic                can_accept,
  gtr_chan_if.source          res_out
);

  logic         busy;
  logic [2:0]   row_idx, col_idx;
  logic         out_valid;
  result_word_t out_word;

  logic       slot_free;
  logic       final_pix;
  logic [2:0] col_rev;
  logic       pix_bit;

  assign slot_free  = !out_valid || res_out.ready;
  assign can_accept = !busy && slot_free;
  assign final_pix  = (row_idx == LAST_ROW) && (col_idx == LAST_COL);
  // column byte c sits at byte slot 4-c; bit r of it is the pixel
  assign col_rev    = LAST_COL - col_idx;
  assign pix_bit    = glyph_row[{col_rev, row_idx}];

  assign res_out.valid   = out_valid;
  assign res_out.payload = out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      row_idx   <= '0;
      col_idx   <= '0;
    end else begin
      if (start) begin
        busy                  <= 1'b1;
        out_valid             <= 1'b1;
        row_idx               <= '0;
        col_idx               <= '0;
        out_word.kind         <= KIND_WINDOW;
        out_word.win_x0       <= cmd.x0;
        out_word.win_y0       <= cmd.y0;
        out_word.win_x1       <= cmd.x0 + 8'(GLYPH_WIDTH - 1);
        out_word.win_y1       <= cmd.y0 + 8'(GLYPH_HEIGHT - 1);
        out_word.pixel_color  <= '0;
        out_word.glyphs_drawn <= cmd.glyphs;
        out_word.last         <= 1'b0;
      end else if (busy && slot_free) begin
        out_valid            <= 1'b1;
        out_word.kind        <= KIND_PIXEL;
        out_word.pixel_color <= pix_bit ? cfg.fg_color : cfg.bg_color;
        out_word.last        <= final_pix;
        if (col_idx == LAST_COL) begin
          col_idx <= '0;
          row_idx <= row_idx + 3'd1;
        end else begin
          col_idx <= col_idx + 3'd1;
        end
        if (final_pix) begin
          busy <= 1'b0;
        end
      end else if (res_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("glyph started while previous glyph still running");

  a_window_first: assert property (@(posedge clk) disable iff (rst)
    start |=> (out_valid && out_word.kind == KIND_WINDOW && busy))
    else $error("window word not loaded on glyph start");

  a_last_is_pixel: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.last) |-> (out_word.kind == KIND_PIXEL && !busy))
    else $error("last flag on a non-final word");

  a_done_after_final: assert property (@(posedge clk) disable iff (rst)
    (busy && slot_free && final_pix) |=> (!busy && out_word.last))
    else $error("sequencer did not finish after final pixel");

endmodule

>>> design/glyph_text_rasterizer.sv
// ----------------------------------------------------------------------------
// glyph_text_rasterizer
// Character generator for a 5x8 column font: each drawn character becomes a
// window word and 40 pixel color words, row by row.
//
//   channel   dir  handshake        word
//   char_in   in   valid/ready      char_code, string_start
//   res_out   out  valid/ready      kind, window, pixel_color, count, last
//   cfg_*     in   cfg_we only      cfg_index selects, cfg_data holds value
//
// A drawn character gives the window word, registered on the accept edge,
// then one pixel per cycle while res_out is ready, from the font row read
// at that edge. Newline, end and ignored characters produce no output.
// Output stalls hold the sequencer; char_in.ready is low while a glyph is
// being emitted. Reset is synchronous and clears cursor, counters and
// channel state; the font ROM needs no initialization pass.
// ----------------------------------------------------------------------------
module glyph_text_rasterizer
  import gtr_pkg::*;
#(
  parameter int MAX_STRING_CHARS = 64
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  gtr_chan_if.sink    char_in,
  gtr_chan_if.source  res_out
);

  cfg_t                cfg;
  draw_cmd_t           cmd;
  char_word_t          in_word;
  logic                accept;
  logic                start;
  logic                can_accept;
  logic [ROW_BITS-1:0] glyph_row;

  assign in_word       = char_in.payload;
  assign char_in.ready = can_accept;
  assign accept        = char_in.valid && can_accept;
  assign start         = accept && cmd.draw;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x      <= '0;
      cfg.origin_y      <= '0;
      cfg.vertical_mode <= 1'b0;
      cfg.fg_color      <= 24'hFFFFFF;
      cfg.bg_color      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X:      cfg.origin_x      <= cfg_data[7:0];
        REG_ORIGIN_Y:      cfg.origin_y      <= cfg_data[7:0];
        REG_VERTICAL_MODE: cfg.vertical_mode <= cfg_data[0];
        REG_FG_COLOR:      cfg.fg_color      <= cfg_data;
        REG_BG_COLOR:      cfg.bg_color      <= cfg_data;
        default: ;
      endcase
    end
  end

  gtr_cursor #(
    .MAX_STRING_CHARS(MAX_STRING_CHARS)
  ) u_cursor (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .word   (in_word),
    .cmd    (cmd)
  );

  gtr_font_rom u_rom (
    .clk   (clk),
    .rd_en (start),
    .addr  (glyph_index(in_word.char_code)),
    .data  (glyph_row)
  );

  gtr_pixel_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .start      (start),
    .cmd        (cmd),
    .glyph_row  (glyph_row),
    .can_accept (can_accept),
    .res_out    (res_out)
  );

endmodule
